@@ rtl/core/xeu_pkg.sv @@
// Shared types and constants of the x86 subset execute unit.
package xeu_pkg;

	localparam int unsigned ADDR_BITS = 16;
	localparam int unsigned MEM_DEPTH = 1 << ADDR_BITS;
	localparam int unsigned IN_W      = 80;
	localparam int unsigned OUT_W     = 80;

	localparam logic [1:0] FN_EXEC = 2'd0;
	localparam logic [1:0] FN_LOAD = 2'd1;
	localparam logic [1:0] FN_READ = 2'd2;

	localparam logic [1:0] CFG_CODE_SEG  = 2'd0;
	localparam logic [1:0] CFG_DATA_SEG  = 2'd1;
	localparam logic [1:0] CFG_STACK_SEG = 2'd2;

	typedef enum logic [3:0] {
		K_NOP,
		K_LOAD,
		K_READ,
		K_ADD_RM,
		K_ADD_ACC,
		K_INCDEC,
		K_PUSH,
		K_POP,
		K_UNSUP
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic        wide;
		logic        to_reg;
		logic        sub;
		logic        es;
		logic [2:0]  rsel;
		logic [7:0]  modrm;
		logic [15:0] disp;
		logic [15:0] imm;
		logic [19:0] mem_addr;
		logic [7:0]  mem_byte;
		logic [2:0]  len;
	} entry_t;

	typedef struct packed {
		logic        unsupported;
		logic [15:0] stack_pointer;
		logic [7:0]  read_byte;
		logic [15:0] result_value;
		logic [15:0] flag_word;
		logic [15:0] next_ip;
	} res_t;

endpackage

@@ rtl/core/xeu_front.sv @@
// Front end: accepts items, classifies the opcode and queues the decoded entries.
module xeu_front import xeu_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [IN_W-1:0] s_tdata,
	output logic            q_valid,
	output entry_t          q_entry,
	input  logic            q_pop
);

	logic [1:0]  func;
	logic [7:0]  op;
	logic [1:0]  md;
	logic [2:0]  rm;
	entry_t      dec;
	entry_t      buf_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  cnt_q;
	logic        push;

	assign func = s_tdata[1:0];
	assign op   = s_tdata[9:2];
	assign md   = s_tdata[17:16];
	assign rm   = s_tdata[12:10];

	always_comb begin
		dec          = '0;
		dec.modrm    = s_tdata[17:10];
		dec.disp     = s_tdata[33:18];
		dec.imm      = s_tdata[49:34];
		dec.mem_addr = s_tdata[69:50];
		dec.mem_byte = s_tdata[77:70];
		dec.rsel     = op[2:0];
		dec.kind     = K_NOP;
		case (func)
			FN_LOAD: dec.kind = K_LOAD;
			FN_READ: dec.kind = K_READ;
			FN_EXEC: begin
				if (op <= 8'd3) begin
					dec.kind   = K_ADD_RM;
					dec.wide   = op[0];
					dec.to_reg = op[1];
					if (md == 2'd1) begin
						dec.len = 3'd3;
					end else if (md == 2'd2 || (md == 2'd0 && rm == 3'd6)) begin
						dec.len = 3'd4;
					end else begin
						dec.len = 3'd2;
					end
				end else if (op == 8'd4 || op == 8'd5) begin
					dec.kind = K_ADD_ACC;
					dec.wide = op[0];
					dec.rsel = 3'd0;
					dec.len  = op[0] ? 3'd3 : 3'd2;
				end else if (op[7:4] == 4'h4) begin
					dec.kind = K_INCDEC;
					dec.wide = 1'b1;
					dec.sub  = op[3];
					dec.len  = 3'd1;
				end else if (op == 8'd6 || op[7:3] == 5'b01010) begin
					dec.kind = K_PUSH;
					dec.wide = 1'b1;
					dec.es   = (op == 8'd6);
					dec.len  = 3'd1;
				end else if (op == 8'd7 || op[7:3] == 5'b01011) begin
					dec.kind = K_POP;
					dec.wide = 1'b1;
					dec.es   = (op == 8'd7);
					dec.len  = 3'd1;
				end else begin
					dec.kind = K_UNSUP;
				end
			end
			default: dec.kind = K_NOP;
		endcase
	end

	assign s_tready = (cnt_q != 2'd2);
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_entry  = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (q_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

@@ rtl/core/xeu_back.sv @@
// Back end: sequencer, register file, flags, data memory and output register.
module xeu_back import xeu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        q_valid,
	input  entry_t      q_entry,
	output logic        q_pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output res_t        m_res
);

	typedef enum logic [6:0] {
		ST_DEC   = 7'b0000001,
		ST_RD_LO = 7'b0000010,
		ST_RD_HI = 7'b0000100,
		ST_EXEC  = 7'b0001000,
		ST_WR_LO = 7'b0010000,
		ST_WR_HI = 7'b0100000,
		ST_DONE  = 7'b1000000
	} st_t;

	localparam logic [15:0] FLAG_MASK = 16'h08D5;

	st_t         state_q;
	entry_t      cur_q;
	logic [15:0] gpr_q [8];
	logic [15:0] es_q, ip_q, flags_q, ds_q, ss_q;
	logic [15:0] opa_q, off_q, seg_q, res_q;
	logic [1:0]  rd_n_q, wr_n_q;
	logic        use_mem_q, raw_q, unsup_q;
	logic [7:0]  lo_q, rb_q, mem_rd_q;
	logic [7:0]  dmem [MEM_DEPTH];
	logic        ovalid_q;
	res_t        out_q;

	// Single signal-selected register read port.
	logic [2:0]  rp_idx, rp_sel;
	logic        rp_wide;
	logic [15:0] rp_word, rp_val;

	logic [1:0]  mod_d;
	logic [2:0]  reg_d, rm_d;
	logic [15:0] base, dsp, ea, sp, push_val;
	logic [15:0] memword, opb;
	logic [31:0] alu_o;
	logic        wr_en, wr_wide, sp_en;
	logic [2:0]  wr_idx;
	logic [15:0] wr_data, sp_data;
	logic [15:0] off_sel;
	logic [19:0] phys_sum;
	logic [ADDR_BITS-1:0] mem_a;
	logic        mem_we;
	logic [7:0]  mem_wd;
	logic        slot_free;

	function automatic logic [31:0] alu(input logic [15:0] a, input logic [15:0] b,
			input logic sub, input logic wide, input logic [15:0] fin);
		logic [15:0] x, y, r, f, ov, hc;
		logic [16:0] full;
		x    = wide ? a : {8'h00, a[7:0]};
		y    = wide ? b : {8'h00, b[7:0]};
		full = sub ? ({1'b0, x} - {1'b0, y}) : ({1'b0, x} + {1'b0, y});
		r    = wide ? full[15:0] : {8'h00, full[7:0]};
		ov   = sub ? ((x ^ y) & (x ^ r)) : (~(x ^ y) & (x ^ r));
		hc   = x ^ y ^ r;
		f     = fin & ~FLAG_MASK;
		f[0]  = wide ? full[16] : full[8];
		f[2]  = ~^r[7:0];
		f[4]  = hc[4];
		f[6]  = (r == 16'h0000);
		f[7]  = wide ? r[15] : r[7];
		f[11] = wide ? ov[15] : ov[7];
		return {f, r};
	endfunction

	assign mod_d = q_entry.modrm[7:6];
	assign reg_d = q_entry.modrm[5:3];
	assign rm_d  = q_entry.modrm[2:0];
	assign sp    = gpr_q[4];

	always_comb begin
		if (state_q == ST_EXEC) begin
			rp_sel  = cur_q.modrm[2:0];
			rp_wide = cur_q.wide;
		end else begin
			rp_sel  = (q_entry.kind == K_ADD_RM) ? reg_d : q_entry.rsel;
			rp_wide = q_entry.wide;
		end
		rp_idx  = rp_wide ? rp_sel : {1'b0, rp_sel[1:0]};
		rp_word = gpr_q[rp_idx];
		if (rp_wide) begin
			rp_val = rp_word;
		end else begin
			rp_val = {8'h00, rp_sel[2] ? rp_word[15:8] : rp_word[7:0]};
		end
	end

	// Effective address of the memory operand and the value a PUSH stores.
	always_comb begin
		case (rm_d)
			3'd0: base = gpr_q[3] + gpr_q[6];
			3'd1: base = gpr_q[3] + gpr_q[7];
			3'd2: base = gpr_q[5] + gpr_q[6];
			3'd3: base = gpr_q[5] + gpr_q[7];
			3'd4: base = gpr_q[6];
			3'd5: base = gpr_q[7];
			3'd6: base = gpr_q[5];
			default: base = gpr_q[3];
		endcase
		case (mod_d)
			2'd1: dsp = {{8{q_entry.disp[7]}}, q_entry.disp[7:0]};
			2'd2: dsp = q_entry.disp;
			default: dsp = 16'h0000;
		endcase
		if (mod_d == 2'd0 && rm_d == 3'd6) begin
			ea = q_entry.disp;
		end else begin
			ea = base + dsp;
		end
		if (q_entry.es) begin
			push_val = es_q;
		end else if (q_entry.rsel == 3'd4) begin
			push_val = sp - 16'd2;
		end else begin
			push_val = rp_val;
		end
	end

	// Execute step: operand selection, adder and register write port.
	always_comb begin
		memword = (rd_n_q == 2'd2) ? {mem_rd_q, lo_q} : {8'h00, mem_rd_q};
		case (cur_q.kind)
			K_ADD_RM:  opb = use_mem_q ? memword : rp_val;
			K_ADD_ACC: opb = cur_q.wide ? cur_q.imm : {8'h00, cur_q.imm[7:0]};
			default:   opb = 16'h0001;
		endcase
		alu_o   = alu(opa_q, opb, cur_q.sub, cur_q.wide, flags_q);
		wr_en   = 1'b0;
		wr_idx  = cur_q.rsel;
		wr_wide = cur_q.wide;
		wr_data = alu_o[15:0];
		sp_en   = 1'b0;
		sp_data = sp + 16'd2;
		if (state_q == ST_EXEC) begin
			case (cur_q.kind)
				K_ADD_RM: begin
					wr_en  = cur_q.to_reg || !use_mem_q;
					wr_idx = cur_q.to_reg ? cur_q.modrm[5:3] : cur_q.modrm[2:0];
				end
				K_ADD_ACC, K_INCDEC: wr_en = 1'b1;
				K_PUSH: begin
					sp_en   = 1'b1;
					sp_data = sp - 16'd2;
				end
				K_POP: begin
					sp_en   = 1'b1;
					wr_en   = !cur_q.es;
					wr_data = memword;
				end
				default: wr_en = 1'b0;
			endcase
		end
	end

	assign off_sel  = (state_q == ST_RD_HI || state_q == ST_WR_HI) ? off_q + 16'd1 : off_q;
	assign phys_sum = {seg_q, 4'h0} + {4'h0, off_sel};
	assign mem_a    = raw_q ? cur_q.mem_addr[ADDR_BITS-1:0] : phys_sum[ADDR_BITS-1:0];
	assign mem_we   = (state_q == ST_WR_LO) || (state_q == ST_WR_HI);
	assign mem_wd   = (state_q == ST_WR_HI) ? res_q[15:8] : res_q[7:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			dmem[mem_a] <= mem_wd;
		end
		mem_rd_q <= dmem[mem_a];
	end

	assign slot_free = !ovalid_q || m_tready;
	assign q_pop     = (state_q == ST_DEC) && q_valid;
	assign m_tvalid  = ovalid_q;
	assign m_res     = out_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q     <= q_entry;
			opa_q     <= (q_entry.kind == K_PUSH) ? push_val : rp_val;
			off_q     <= (q_entry.kind == K_ADD_RM) ? ea :
			             (q_entry.kind == K_PUSH) ? sp - 16'd2 : sp;
			seg_q     <= (q_entry.kind == K_ADD_RM) ? ds_q : ss_q;
			use_mem_q <= (q_entry.kind == K_ADD_RM) && (mod_d != 2'd3);
			raw_q     <= (q_entry.kind == K_LOAD) || (q_entry.kind == K_READ);
			rd_n_q    <= 2'd0;
			wr_n_q    <= 2'd0;
			case (q_entry.kind)
				K_ADD_RM: begin
					if (mod_d != 2'd3) begin
						rd_n_q <= q_entry.wide ? 2'd2 : 2'd1;
						if (!q_entry.to_reg) begin
							wr_n_q <= q_entry.wide ? 2'd2 : 2'd1;
						end
					end
				end
				K_POP:  rd_n_q <= 2'd2;
				K_READ: rd_n_q <= 2'd1;
				K_PUSH: wr_n_q <= 2'd2;
				K_LOAD: wr_n_q <= 2'd1;
				default: rd_n_q <= 2'd0;
			endcase
		end
		if (state_q == ST_RD_HI) begin
			lo_q <= mem_rd_q;
		end
		if (state_q == ST_EXEC) begin
			res_q   <= 16'h0000;
			rb_q    <= 8'h00;
			unsup_q <= (cur_q.kind == K_UNSUP);
			case (cur_q.kind)
				K_ADD_RM, K_ADD_ACC, K_INCDEC: res_q <= alu_o[15:0];
				K_PUSH: res_q <= opa_q;
				K_POP:  res_q <= memword;
				K_LOAD: res_q <= {8'h00, cur_q.mem_byte};
				K_READ: rb_q  <= mem_rd_q;
				default: res_q <= 16'h0000;
			endcase
		end
		if (state_q == ST_DONE && slot_free) begin
			out_q.next_ip       <= ip_q;
			out_q.flag_word     <= flags_q;
			out_q.result_value  <= res_q;
			out_q.read_byte     <= rb_q;
			out_q.stack_pointer <= sp;
			out_q.unsupported   <= unsup_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_DEC;
			ovalid_q <= 1'b0;
			es_q     <= '0;
			ip_q     <= '0;
			flags_q  <= '0;
			ds_q     <= '0;
			ss_q     <= '0;
			for (int i = 0; i < 8; i++) begin
				gpr_q[i] <= '0;
			end
		end else begin
			if (cfg_we && cfg_index == CFG_DATA_SEG) begin
				ds_q <= cfg_data;
			end
			if (cfg_we && cfg_index == CFG_STACK_SEG) begin
				ss_q <= cfg_data;
			end
			if (state_q == ST_EXEC) begin
				ip_q <= ip_q + {13'd0, cur_q.len};
				case (cur_q.kind)
					K_ADD_RM, K_ADD_ACC: flags_q <= alu_o[31:16];
					K_INCDEC: flags_q <= {alu_o[31:17], flags_q[0]};
					K_POP: begin
						if (cur_q.es) begin
							es_q <= memword;
						end
					end
					default: flags_q <= flags_q;
				endcase
			end
			// SP update first; a register write to SP (POP SP) takes priority.
			for (int i = 0; i < 8; i++) begin
				if (sp_en && i == 4) begin
					gpr_q[i] <= sp_data;
				end
				if (wr_en && wr_wide && wr_idx == i[2:0]) begin
					gpr_q[i] <= wr_data;
				end
				if (wr_en && !wr_wide && {1'b0, wr_idx[1:0]} == i[2:0]) begin
					if (wr_idx[2]) begin
						gpr_q[i][15:8] <= wr_data[7:0];
					end else begin
						gpr_q[i][7:0] <= wr_data[7:0];
					end
				end
			end
			if (m_tready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ST_DEC: begin
					if (q_valid) begin
						if ((q_entry.kind == K_ADD_RM && mod_d != 2'd3) ||
						    q_entry.kind == K_POP || q_entry.kind == K_READ) begin
							state_q <= ST_RD_LO;
						end else begin
							state_q <= ST_EXEC;
						end
					end
				end
				ST_RD_LO: state_q <= (rd_n_q == 2'd2) ? ST_RD_HI : ST_EXEC;
				ST_RD_HI: state_q <= ST_EXEC;
				ST_EXEC:  state_q <= (wr_n_q != 2'd0) ? ST_WR_LO : ST_DONE;
				ST_WR_LO: state_q <= (wr_n_q == 2'd2) ? ST_WR_HI : ST_DONE;
				ST_WR_HI: state_q <= ST_DONE;
				ST_DONE: begin
					if (slot_free) begin
						ovalid_q <= 1'b1;
						state_q  <= ST_DEC;
					end
				end
				default: state_q <= ST_DEC;
			endcase
		end
	end

endmodule

@@ rtl/core/x86_16_subset_execute_unit_top.sv @@
// Top level of the x86 subset execute unit: stream ports, front, back.
// The input stream carries one decoded item per handshake: either an
// instruction to execute (ADD forms, INC/DEC, PUSH/POP) or a direct load or
// read of one data memory byte. Each accepted item yields exactly one output
// item with the new IP, flags, written value, read byte, SP and an
// unsupported mark, in the order the items were accepted.
// The front end classifies each item and places it in a two-entry queue, so
// s_tready stays high while the back end is busy, until the queue is full.
// The back end is a sequencer around a single-port byte memory. An item passes
// through a decode step, a read step for each memory byte read, an execute
// step, a write step for each memory byte written and a step that loads the
// output register. The back end takes the next item from the queue only after
// it has loaded the output register for the current one.
// The configuration port may be written only while the block is idle; writes
// to the code segment index are accepted and have no effect.
// Reset clears the registers, flags, IP, ES, segments and queue; the data
// memory holds no defined value until written. When m_tready is low the
// output register holds its item and the back end waits in its final step.
module x86_16_subset_execute_unit_top import xeu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [15:0]      cfg_data,
	input  logic             s_tvalid,
	output logic             s_tready,
	// func, opcode, modrm, disp, imm, mem_addr, mem_byte from bit 0 up; zero fill.
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// next_ip, flag_word, result_value, read_byte, stack_pointer, unsupported
	// from bit 0 up; zero fill.
	output logic [OUT_W-1:0] m_tdata
);

	logic   q_valid;
	logic   q_pop;
	entry_t q_entry;
	res_t   res;

	xeu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_valid  (q_valid),
		.q_entry  (q_entry),
		.q_pop    (q_pop)
	);

	xeu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.q_pop     (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_res     (res)
	);

	assign m_tdata = {7'h00, res};

endmodule

@@ rtl/core/xeu_checker.sv @@
// Port-level checker for the x86 subset execute unit and its bind.
module xeu_checker import xeu_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output item dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("output item changed while stalled");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_W-1:73] == '0)
		else $error("output fill bits not zero");

	a_unsup_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[72] |-> m_tdata[55:32] == '0)
		else $error("unsupported item carries data");

endmodule

bind x86_16_subset_execute_unit_top xeu_checker u_xeu_checker (.*);
